>>> hdl/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types and constants for the terrain line-of-sight block.
// ----------------------------------------------------------------------------
`default_nettype none

package tls_pkg;

    // default store side in cells
    localparam int DEF_MAX_SIDE = 256;

    // squared radius up to which a cell in the map and in range is seen without a walk
    localparam logic [16:0] NEAR_R2 = 17'd9;

    // depth of the queue between front and back
    localparam int QDEPTH = 2;

    // register reset values
    localparam logic [8:0]         RST_MAP_SIDE = 9'd256;
    localparam logic [7:0]         RST_RANGE    = 8'd32;
    localparam logic signed [23:0] RST_EYE      = 24'sd0;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MAP_WIDTH   = 3'd0,
        CFG_MAP_HEIGHT  = 3'd1,
        CFG_OBSERVER_X  = 3'd2,
        CFG_OBSERVER_Y  = 3'd3,
        CFG_EYE_OFFSET  = 3'd4,
        CFG_RANGE_CELLS = 3'd5,
        CFG_CELL_METRES = 3'd6
    } t_cfg_idx;

    // input command codes
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // what the back end must do with a queued request
    typedef enum logic [1:0] {
        K_LOAD   = 2'd0,
        K_ANSWER = 2'd1,
        K_WALK   = 2'd2
    } t_kind;

    // back end states
    typedef enum logic [2:0] {
        B_IDLE  = 3'd0,
        B_RDO   = 3'd1,
        B_RDT   = 3'd2,
        B_DIV   = 3'd3,
        B_WALK  = 3'd4,
        B_DRAIN = 3'd5,
        B_OUT   = 3'd6
    } t_bstate;

    // effective configuration (map sides already clamped)
    typedef struct packed {
        logic [8:0]         w;
        logic [8:0]         h;
        logic [7:0]         ox;
        logic [7:0]         oy;
        logic signed [23:0] eye;
        logic [7:0]         rng;
    } t_cfg;

    // one classified request
    typedef struct packed {
        t_kind              kind;
        logic               ans;
        logic [7:0]         x;
        logic [7:0]         y;
        logic signed [23:0] hval;
        logic signed [8:0]  dx;
        logic signed [8:0]  dy;
        logic [7:0]         s;
    } t_entry;

endpackage

`default_nettype wire

>>> hdl/terrain_line_of_sight.sv
// ----------------------------------------------------------------------------
// terrain_line_of_sight
// Height map store with line-of-sight queries from a configured observer.
// ----------------------------------------------------------------------------
// A load request stores one height in the back end. A query that is settled
// by bounds, the observer cell, range or nearness is answered in order at one
// per cycle while the result stream is not stalled. Any other query walks the
// ray: setup (the pop, two store reads and two divides), then the S-1 samples,
// S = max(|dx|,|dy|), with four corner reads per sample on the single store
// read port, then drain and answer. Requests are queued behind a walk.
`default_nettype none

module terrain_line_of_sight import tls_pkg::*; #(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [39:0]  i_s_tdata,   // cell_x[7:0], cell_y[15:8], height_value[39:16]
    input  wire         i_s_tuser,   // cmd[0]
    // result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,   // visible[0], zero fill above
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [2:0]   i_cfg_index,
    input  wire [23:0]  i_cfg_data
);

    // coordinates are 8 bits, so a wider store behaves as a 256-cell side
    localparam int SIDE_CAP = (MAX_SIDE < 256) ? MAX_SIDE : 256;

    logic [8:0]         r_w, r_h;
    logic [7:0]         r_ox, r_oy, r_rng;
    logic signed [23:0] r_eye;
    t_cfg               c_cfg;

    logic   f_valid, q_ready, q_valid, q_pop, b_vis;
    t_entry f_entry, q_entry;

    function automatic logic [8:0] eff_side(input logic [8:0] v);
        if (v == '0) begin
            return 9'd1;
        end else if (32'(v) > SIDE_CAP) begin
            return 9'(SIDE_CAP);
        end
        return v;
    endfunction

    // configuration registers; cell size scales every slope alike and is dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= RST_MAP_SIDE;
            r_h   <= RST_MAP_SIDE;
            r_ox  <= '0;
            r_oy  <= '0;
            r_eye <= RST_EYE;
            r_rng <= RST_RANGE;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAP_WIDTH:   r_w   <= i_cfg_data[8:0];
                CFG_MAP_HEIGHT:  r_h   <= i_cfg_data[8:0];
                CFG_OBSERVER_X:  r_ox  <= i_cfg_data[7:0];
                CFG_OBSERVER_Y:  r_oy  <= i_cfg_data[7:0];
                CFG_EYE_OFFSET:  r_eye <= $signed(i_cfg_data);
                CFG_RANGE_CELLS: r_rng <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        c_cfg.w   = eff_side(r_w);
        c_cfg.h   = eff_side(r_h);
        c_cfg.ox  = r_ox;
        c_cfg.oy  = r_oy;
        c_cfg.eye = r_eye;
        c_cfg.rng = r_rng;
    end

    tls_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (c_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_cmd   (i_s_tuser),
        .i_x     (i_s_tdata[7:0]),
        .i_y     (i_s_tdata[15:8]),
        .i_hval  ($signed(i_s_tdata[39:16])),
        .o_valid (f_valid),
        .i_ready (q_ready),
        .o_entry (f_entry)
    );

    tls_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_entry (f_entry),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_entry)
    );

    tls_back #(.MAX_SIDE(MAX_SIDE)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (c_cfg),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_visible (b_vis)
    );

    assign o_m_tdata = {7'b0, b_vis};

endmodule

`default_nettype wire

>>> hdl/tls_front.sv
// ----------------------------------------------------------------------------
// tls_front
// Accepts requests, drops loads outside the store and settles every query
// that needs no ray walk. Walk queries leave with their deltas and step count.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_front import tls_pkg::*; #(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cfg               i_cfg,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire                i_cmd,
    input  wire [7:0]          i_x,
    input  wire [7:0]          i_y,
    input  wire signed [23:0]  i_hval,
    output logic               o_valid,
    input  wire                i_ready,
    output t_entry             o_entry
);

    logic              r_v;
    t_entry            r_ent;
    t_entry            c_ent;
    logic              c_keep;
    logic signed [8:0] c_dx, c_dy;
    logic [7:0]        c_adx, c_ady;
    logic [15:0]       c_sqx, c_sqy, c_rng2;
    logic [16:0]       c_r2;

    // geometry of the query
    always_comb begin
        c_dx   = $signed({1'b0, i_x}) - $signed({1'b0, i_cfg.ox});
        c_dy   = $signed({1'b0, i_y}) - $signed({1'b0, i_cfg.oy});
        c_adx  = c_dx[8] ? 8'(-c_dx) : c_dx[7:0];
        c_ady  = c_dy[8] ? 8'(-c_dy) : c_dy[7:0];
        c_sqx  = c_adx * c_adx;
        c_sqy  = c_ady * c_ady;
        c_rng2 = i_cfg.rng * i_cfg.rng;
        c_r2   = {1'b0, c_sqx} + {1'b0, c_sqy};
    end

    // classification
    always_comb begin
        c_ent.kind = K_ANSWER;
        c_ent.ans  = 1'b0;
        c_ent.x    = i_x;
        c_ent.y    = i_y;
        c_ent.hval = i_hval;
        c_ent.dx   = c_dx;
        c_ent.dy   = c_dy;
        c_ent.s    = (c_adx > c_ady) ? c_adx : c_ady;
        c_keep     = 1'b1;
        if (i_cmd == CMD_LOAD) begin
            c_ent.kind = K_LOAD;
            c_keep     = (32'(i_x) < MAX_SIDE) && (32'(i_y) < MAX_SIDE);
        end else if ({1'b0, i_x} >= i_cfg.w || {1'b0, i_y} >= i_cfg.h) begin
            c_ent.ans = 1'b0;
        end else if (i_x == i_cfg.ox && i_y == i_cfg.oy) begin
            c_ent.ans = 1'b1;
        end else if (c_r2 > {1'b0, c_rng2}) begin
            c_ent.ans = 1'b0;
        end else if (c_r2 <= NEAR_R2) begin
            c_ent.ans = 1'b1;
        end else begin
            c_ent.kind = K_WALK;
        end
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_entry = r_ent;

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_v <= c_keep;
        end else if (i_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ent <= c_ent;
        end
    end

endmodule

`default_nettype wire

>>> hdl/tls_fifo.sv
// ----------------------------------------------------------------------------
// tls_fifo
// Short request queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_fifo import tls_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_push,
    output logic    o_ready,
    input  t_entry  i_entry,
    output logic    o_valid,
    input  wire     i_pop,
    output t_entry  o_entry
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_entry        r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          c_wr, c_rd;

    assign o_ready = (32'(r_cnt) < QDEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];
    assign c_wr    = i_push && o_ready;
    assign c_rd    = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (c_wr) begin
                r_wp <= (32'(r_wp) == QDEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (c_rd) begin
                r_rp <= (32'(r_rp) == QDEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (c_wr && !c_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (c_rd && !c_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_wr) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

`default_nettype wire

>>> hdl/tls_back.sv
// ----------------------------------------------------------------------------
// tls_back
// Height store, ray walk and result register. A walk reads the eye and target
// heights, divides each axis delta once, then steps the ray four store reads
// per sample through a bilinear and slope compare pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_back import tls_pkg::*; #(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_cfg    i_cfg,
    input  wire     i_q_valid,
    input  t_entry  i_q_entry,
    output logic    o_q_pop,
    output logic    o_valid,
    input  wire     i_ready,
    output logic    o_visible
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int AW = 2 * CW;
    localparam logic [4:0] DIV_STEPS = 5'd25;

    // height store
    logic signed [23:0] r_mem [1 << AW];
    logic signed [23:0] r_rdata;
    logic               c_we;
    logic [AW-1:0]      c_raddr, c_waddr;

    t_bstate r_state, n_state;

    // walk registers
    logic [7:0]         r_tx, r_ty, r_s, r_i;
    logic signed [8:0]  r_dy;
    logic signed [24:0] r_eye;
    logic signed [25:0] r_tdh;
    logic [24:0]        r_num;
    logic [8:0]         r_rem;
    logic [4:0]         r_dcnt;
    logic               r_axis;
    logic signed [18:0] r_dqx, r_dqy;
    logic [7:0]         r_edx, r_edy, r_ex, r_ey;
    logic [23:0]        r_vx, r_vy;
    logic signed [49:0] r_tacc;
    logic [1:0]         r_ph;
    logic               r_fail;

    // read tracking and gathered corners
    logic               r_rv;
    logic [1:0]         r_rph;
    logic signed [23:0] r_h00, r_h10, r_h01;
    logic [15:0]        r_ifx, r_ify;
    logic signed [49:0] r_itacc;

    // compare pipeline
    logic               r_v1, r_v2, r_v3, r_v4;
    logic signed [23:0] r_s1_h00, r_s2_h00;
    logic signed [24:0] r_s1_d10, r_s1_d01;
    logic signed [25:0] r_s1_dd;
    logic [15:0]        r_s1_fx, r_s1_fy;
    logic [31:0]        r_s1_fxfy;
    logic signed [41:0] r_s2_a, r_s2_b;
    logic signed [58:0] r_s2_c;
    logic signed [45:0] r_s3_sd;
    logic signed [55:0] r_s4_p;
    logic signed [49:0] r_s1_t, r_s2_t, r_s3_t, r_s4_t;

    // output register
    logic r_ov, r_vis;

    // control
    logic c_pop, c_ld, c_res, c_issue, c_walking, c_slot, c_busy;
    logic c_obs_in;

    // sample position
    logic [7:0]         c_qx, c_qy, c_x1, c_y1, c_sx, c_sy;
    logic [15:0]        c_fx, c_fy;
    logic signed [18:0] c_dq;
    logic signed [41:0] c_tdiff;
    logic signed [44:0] c_val;

    function automatic logic [AW-1:0] addr_of(input logic [7:0] x, input logic [7:0] y);
        return {CW'(y), CW'(x)};
    endfunction

    // axis delta shifted into a non-negative dividend
    function automatic logic [8:0] ofs(input logic signed [8:0] d, input logic [7:0] s);
        logic signed [9:0] t;
        t = 10'(d) + $signed({2'b0, s});
        return t[8:0];
    endfunction

    // one ray step on one axis: position in Q8.16 plus exact remainder
    function automatic logic [31:0] adv(input logic [23:0] v, input logic [7:0] e,
                                        input logic signed [18:0] dq,
                                        input logic [7:0] ed, input logic [7:0] s);
        logic signed [25:0] t;
        logic [8:0]         es;
        es = {1'b0, e} + {1'b0, ed};
        t  = $signed({2'b0, v}) + 26'(dq);
        if (es >= {1'b0, s}) begin
            es = es - {1'b0, s};
            t  = t + 26'sd1;
        end
        return {t[23:0], es[7:0]};
    endfunction

    assign c_slot    = !r_ov || i_ready;
    assign c_walking = (r_state == B_WALK) || (r_state == B_DRAIN);
    assign c_busy    = r_rv || r_v1 || r_v2 || r_v3 || r_v4;
    assign c_obs_in  = ({1'b0, i_cfg.ox} < i_cfg.w) && ({1'b0, i_cfg.oy} < i_cfg.h);
    assign c_dq      = $signed({1'b0, r_num[17:0]}) - 19'sd65536;
    assign c_tdiff   = $signed({r_tdh, 16'b0});
    assign c_waddr   = addr_of(i_q_entry.x, i_q_entry.y);

    // sample corners, clamped to the map edge
    always_comb begin
        c_qx = r_vx[23:16];
        c_fx = r_vx[15:0];
        c_qy = r_vy[23:16];
        c_fy = r_vy[15:0];
        if ({1'b0, c_qx} >= i_cfg.w) begin
            c_qx = 8'(i_cfg.w - 9'd1);
            c_fx = '0;
        end
        if ({1'b0, c_qy} >= i_cfg.h) begin
            c_qy = 8'(i_cfg.h - 9'd1);
            c_fy = '0;
        end
        c_x1 = (c_fx != '0 && ({1'b0, c_qx} + 9'd1) < i_cfg.w) ? c_qx + 8'd1 : c_qx;
        c_y1 = (c_fy != '0 && ({1'b0, c_qy} + 9'd1) < i_cfg.h) ? c_qy + 8'd1 : c_qy;
        c_sx = r_ph[0] ? c_x1 : c_qx;
        c_sy = r_ph[1] ? c_y1 : c_qy;
    end

    // next state and control
    always_comb begin
        n_state = r_state;
        c_pop   = 1'b0;
        c_we    = 1'b0;
        c_ld    = 1'b0;
        c_res   = 1'b0;
        c_issue = 1'b0;
        c_raddr = addr_of(r_tx, r_ty);
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_entry.kind)
                        K_LOAD: begin
                            c_we  = 1'b1;
                            c_pop = 1'b1;
                        end
                        K_ANSWER: begin
                            if (c_slot) begin
                                c_ld  = 1'b1;
                                c_res = i_q_entry.ans;
                                c_pop = 1'b1;
                            end
                        end
                        K_WALK: begin
                            c_pop   = 1'b1;
                            n_state = B_RDO;
                        end
                        default: c_pop = 1'b1;
                    endcase
                end
            end
            B_RDO: begin
                c_raddr = addr_of(i_cfg.ox, i_cfg.oy);
                n_state = B_RDT;
            end
            B_RDT: n_state = B_DIV;
            B_DIV: begin
                if (r_dcnt == DIV_STEPS && r_axis) begin
                    n_state = B_WALK;
                end
            end
            B_WALK: begin
                if (r_fail) begin
                    n_state = B_OUT;
                end else begin
                    c_issue = 1'b1;
                    c_raddr = addr_of(c_sx, c_sy);
                    if (r_ph == 2'd3 && r_i == r_s - 8'd1) begin
                        n_state = B_DRAIN;
                    end
                end
            end
            B_DRAIN: begin
                if (r_fail || !c_busy) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (c_slot) begin
                    c_ld    = 1'b1;
                    c_res   = !r_fail;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_q_pop   = c_pop;
    assign o_valid   = r_ov;
    assign o_visible = r_vis;

    // store port
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem[c_waddr] <= i_q_entry.hval;
        end
        r_rdata <= r_mem[c_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
            r_rv    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_fail  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_ld) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            r_rv <= c_issue;
            r_v1 <= c_walking && r_rv && r_rph == 2'd3;
            r_v2 <= c_walking && r_v1;
            r_v3 <= c_walking && r_v2;
            r_v4 <= c_walking && r_v3;
            if (r_state == B_DIV && r_dcnt == DIV_STEPS && r_axis) begin
                r_fail <= 1'b0;
            end else if (c_walking && r_v4 && 56'(r_s4_t) < r_s4_p) begin
                r_fail <= 1'b1;
            end
        end
    end

    // walk setup, division and stepping
    always_ff @(posedge i_clk) begin
        if (c_ld) begin
            r_vis <= c_res;
        end
        if (r_state == B_IDLE && c_pop && i_q_entry.kind == K_WALK) begin
            r_tx   <= i_q_entry.x;
            r_ty   <= i_q_entry.y;
            r_dy   <= i_q_entry.dy;
            r_s    <= i_q_entry.s;
            r_num  <= {ofs(i_q_entry.dx, i_q_entry.s), 16'b0};
            r_rem  <= '0;
            r_dcnt <= '0;
            r_axis <= 1'b0;
        end
        if (r_state == B_RDT) begin
            r_eye <= (c_obs_in ? 25'(r_rdata) : 25'sd0) + 25'(i_cfg.eye);
        end
        if (r_state == B_DIV) begin
            if (!r_axis && r_dcnt == '0) begin
                r_tdh <= 26'(r_rdata) - 26'(r_eye);
            end
            if (r_dcnt != DIV_STEPS) begin
                // restoring divide, one quotient bit a cycle
                if ({r_rem[7:0], r_num[24]} >= {1'b0, r_s}) begin
                    r_rem <= {r_rem[7:0], r_num[24]} - {1'b0, r_s};
                    r_num <= {r_num[23:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[7:0], r_num[24]};
                    r_num <= {r_num[23:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 5'd1;
            end else if (!r_axis) begin
                r_dqx  <= c_dq;
                r_edx  <= r_rem[7:0];
                r_axis <= 1'b1;
                r_num  <= {ofs(r_dy, r_s), 16'b0};
                r_rem  <= '0;
                r_dcnt <= '0;
            end else begin
                r_dqy          <= c_dq;
                r_edy          <= r_rem[7:0];
                {r_vx, r_ex}   <= adv({i_cfg.ox, 16'b0}, 8'd0, r_dqx, r_edx, r_s);
                {r_vy, r_ey}   <= adv({i_cfg.oy, 16'b0}, 8'd0, c_dq, r_rem[7:0], r_s);
                r_i            <= 8'd1;
                r_tacc         <= 50'(c_tdiff);
                r_ph           <= '0;
            end
        end
        if (c_issue) begin
            r_ph <= r_ph + 2'd1;
            if (r_ph == 2'd3) begin
                r_ifx        <= c_fx;
                r_ify        <= c_fy;
                r_itacc      <= r_tacc;
                {r_vx, r_ex} <= adv(r_vx, r_ex, r_dqx, r_edx, r_s);
                {r_vy, r_ey} <= adv(r_vy, r_ey, r_dqy, r_edy, r_s);
                r_tacc       <= r_tacc + 50'(c_tdiff);
                r_i          <= r_i + 8'd1;
            end
        end
        r_rph <= r_ph;
    end

    // corner capture
    always_ff @(posedge i_clk) begin
        if (r_rv) begin
            case (r_rph)
                2'd0: r_h00 <= r_rdata;
                2'd1: r_h10 <= r_rdata;
                2'd2: r_h01 <= r_rdata;
                default: ;
            endcase
        end
    end

    // bilinear height and slope compare pipeline
    assign c_val = $signed({r_s2_h00, 16'b0}) + r_s2_a + r_s2_b + 45'(r_s2_c >>> 16);

    always_ff @(posedge i_clk) begin
        // corner differences and fraction product
        r_s1_h00  <= r_h00;
        r_s1_d10  <= 25'(r_h10) - 25'(r_h00);
        r_s1_d01  <= 25'(r_h01) - 25'(r_h00);
        r_s1_dd   <= 26'(r_rdata) - 26'(r_h10) - 26'(r_h01) + 26'(r_h00);
        r_s1_fx   <= r_ifx;
        r_s1_fy   <= r_ify;
        r_s1_fxfy <= r_ifx * r_ify;
        r_s1_t    <= r_itacc;
        // weighted terms
        r_s2_a    <= r_s1_d10 * $signed({1'b0, r_s1_fx});
        r_s2_b    <= r_s1_d01 * $signed({1'b0, r_s1_fy});
        r_s2_c    <= r_s1_dd * $signed({1'b0, r_s1_fxfy});
        r_s2_h00  <= r_s1_h00;
        r_s2_t    <= r_s1_t;
        // height above the eye in Q.16
        r_s3_sd   <= 46'(c_val) - 46'($signed({r_eye, 16'b0}));
        r_s3_t    <= r_s2_t;
        // scale by the step count
        r_s4_p    <= r_s3_sd * $signed({1'b0, r_s});
        r_s4_t    <= r_s3_t;
    end

endmodule

`default_nettype wire
